>>> rtl/hea_pkg.sv
// Shared types and constants for the heading error angle pipeline.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package hea_pkg;

  // Port field widths
  localparam int ANG_W = 16;   // heading and direction angle, 1/128 degree
  localparam int CRD_W = 16;   // target coordinates
  localparam int OUT_W = 17;   // control angle

  // Internal CORDIC widths: 16 bit coordinates scaled by 2^12, pre-rotation
  // negation and CORDIC gain stay well inside 31 bits; the angle
  // accumulator (1/65536 degree) stays below 200 degrees.
  localparam int COORD_SH = 12;
  localparam int XY_W     = 31;
  localparam int Z_W      = 26;

  localparam int ATAN_LEN = 24;
  localparam int IDX_W    = 5;

  // Angle constants
  localparam int DEG90_ACC  = 5898240;  // 90 degrees in 1/65536
  localparam int DEG90_OUT  = 11520;    // 90 degrees in 1/128
  localparam int DEG180_OUT = 23040;
  localparam int DEG360_OUT = 46080;
  localparam int ACC_SH     = 9;        // 1/65536 -> 1/128
  localparam int ROUND_HALF = 256;      // half of one output step

  // One beat as it moves down the pipeline
  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
    logic signed [ANG_W-1:0] dir;
    logic                    degen;
  } stage_t;

  // atan(2^-idx) in 1/65536 degree, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [IDX_W-1:0] idx);
    logic signed [Z_W-1:0] val;
    case (idx)
      5'd0:    val = Z_W'(2949120);
      5'd1:    val = Z_W'(1740967);
      5'd2:    val = Z_W'(919879);
      5'd3:    val = Z_W'(466945);
      5'd4:    val = Z_W'(234379);
      5'd5:    val = Z_W'(117304);
      5'd6:    val = Z_W'(58666);
      5'd7:    val = Z_W'(29335);
      5'd8:    val = Z_W'(14668);
      5'd9:    val = Z_W'(7334);
      5'd10:   val = Z_W'(3667);
      5'd11:   val = Z_W'(1833);
      5'd12:   val = Z_W'(917);
      5'd13:   val = Z_W'(458);
      5'd14:   val = Z_W'(229);
      5'd15:   val = Z_W'(115);
      5'd16:   val = Z_W'(57);
      5'd17:   val = Z_W'(29);
      5'd18:   val = Z_W'(14);
      5'd19:   val = Z_W'(7);
      5'd20:   val = Z_W'(4);
      5'd21:   val = Z_W'(2);
      5'd22:   val = Z_W'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/hea_if.sv
// Valid/ready channel interfaces for the input and result beats.
// Depends on hea_pkg for field widths.
`timescale 1ns / 1ps

interface hea_in_if;
  import hea_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] heading;
  logic signed [CRD_W-1:0] tgt_x;
  logic signed [CRD_W-1:0] tgt_y;

  modport source (output valid, output heading, output tgt_x, output tgt_y,
                  input ready);
  modport sink   (input valid, input heading, input tgt_x, input tgt_y,
                  output ready);
endinterface

interface hea_out_if;
  import hea_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] control_angle;
  logic                    degenerate;

  modport source (output valid, output control_angle, output degenerate,
                  input ready);
  modport sink   (input valid, input control_angle, input degenerate,
                  output ready);
endinterface

>>> rtl/hea_prep.sv
// Entry stage: direction angle from heading, quadrant pre-rotation and
// coordinate scaling into the CORDIC format. Depends on hea_pkg.
`timescale 1ns / 1ps

module hea_prep (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic signed [hea_pkg::ANG_W-1:0] heading,
  input  logic signed [hea_pkg::CRD_W-1:0] tgt_x,
  input  logic signed [hea_pkg::CRD_W-1:0] tgt_y,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output hea_pkg::stage_t                dn_data
);
  import hea_pkg::*;

  logic                    valid_r;
  stage_t                  data_r;
  stage_t                  data_nxt;
  logic signed [XY_W-1:0]  xs;
  logic signed [XY_W-1:0]  ys;
  logic signed [OUT_W-1:0] d_wide;

  // Scale coordinates by 2^COORD_SH
  assign xs = {{(XY_W-CRD_W-COORD_SH){tgt_x[CRD_W-1]}}, tgt_x, {COORD_SH{1'b0}}};
  assign ys = {{(XY_W-CRD_W-COORD_SH){tgt_y[CRD_W-1]}}, tgt_y, {COORD_SH{1'b0}}};

  always_comb begin
    // Direction angle: 90 minus heading, wrapped once into (-180, 180]
    d_wide = OUT_W'(DEG90_OUT) - {heading[ANG_W-1], heading};
    if (d_wide > OUT_W'(DEG180_OUT)) begin
      d_wide = d_wide - OUT_W'(DEG360_OUT);
    end

    // Left half plane: rotate into the right half, seed the accumulator
    data_nxt.x = xs;
    data_nxt.y = ys;
    data_nxt.z = '0;
    if (tgt_x[CRD_W-1]) begin
      if (!tgt_y[CRD_W-1]) begin
        data_nxt.x = ys;
        data_nxt.y = -xs;
        data_nxt.z = Z_W'(DEG90_ACC);
      end else begin
        data_nxt.x = -ys;
        data_nxt.y = xs;
        data_nxt.z = -Z_W'(DEG90_ACC);
      end
    end
    data_nxt.dir   = d_wide[ANG_W-1:0];
    data_nxt.degen = (tgt_x == '0) && (tgt_y == '0);
  end

  // Advance when empty or downstream takes the held beat
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

>>> rtl/hea_cordic_stage.sv
// One registered CORDIC vectoring iteration with a fixed shift index.
// Depends on hea_pkg for the beat type and the arctangent table.
`timescale 1ns / 1ps

module hea_cordic_stage #(
  parameter int unsigned STAGE_IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  hea_pkg::stage_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output hea_pkg::stage_t dn_data
);
  import hea_pkg::*;

  logic                   valid_r;
  stage_t                 data_r;
  stage_t                 data_nxt;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  step_ang;

  // Arithmetic shifts round toward minus infinity
  assign dx       = $signed(up_data.y) >>> STAGE_IDX;
  assign dy       = $signed(up_data.x) >>> STAGE_IDX;
  assign step_ang = atan_q16(IDX_W'(STAGE_IDX));

  // Rotate toward the x axis; accumulate the angle taken
  always_comb begin
    data_nxt = up_data;
    if (!up_data.y[XY_W-1]) begin
      data_nxt.x = up_data.x + dx;
      data_nxt.y = up_data.y - dy;
      data_nxt.z = up_data.z + step_ang;
    end else begin
      data_nxt.x = up_data.x - dx;
      data_nxt.y = up_data.y + dy;
      data_nxt.z = up_data.z - step_ang;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

>>> rtl/hea_post.sv
// Output stage: round and clamp the bearing, subtract it from the direction
// angle and hold the result beat. Depends on hea_pkg.
`timescale 1ns / 1ps

module hea_post (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  hea_pkg::stage_t                  up_data,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output logic signed [hea_pkg::OUT_W-1:0] control_angle,
  output logic                             degenerate
);
  import hea_pkg::*;

  logic                    valid_r;
  logic signed [OUT_W-1:0] angle_r;
  logic                    degen_r;
  logic signed [OUT_W-1:0] angle_nxt;
  logic signed [Z_W-1:0]   z_sum;
  logic signed [Z_W-1:0]   bear;

  always_comb begin
    // Round accumulator to 1/128 degree, halves up
    z_sum = up_data.z + Z_W'(ROUND_HALF);
    bear  = z_sum >>> ACC_SH;
    // Clamp bearing to +-180
    if (bear > Z_W'(DEG180_OUT)) begin
      bear = Z_W'(DEG180_OUT);
    end else if (bear < -Z_W'(DEG180_OUT)) begin
      bear = -Z_W'(DEG180_OUT);
    end
    angle_nxt = {up_data.dir[ANG_W-1], up_data.dir} - bear[OUT_W-1:0];
    // Zero target has no bearing
    if (up_data.degen) begin
      angle_nxt = '0;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      angle_r <= angle_nxt;
      degen_r <= up_data.degen;
    end
  end

  assign dn_valid      = valid_r;
  assign control_angle = angle_r;
  assign degenerate    = degen_r;

endmodule

>>> rtl/heading_error_angle.sv
// Top level of the heading error angle pipeline.
// Depends on hea_pkg, hea_if, hea_prep, hea_cordic_stage and hea_post.
`timescale 1ns / 1ps
//
// Usage:
//   in_ch  carries one beat per target: heading (1/128 degree, clockwise from
//          the y axis) and tgt_x / tgt_y offsets.
//   out_ch returns one beat per input beat, in order: control_angle is the
//          direction angle (90 degrees minus heading, wrapped) minus the
//          target bearing atan2(y, x), in 1/128 degree and not rewrapped.
//          degenerate marks a zero target vector; control_angle is then 0.
// Registers: entry register, one register per CORDIC iteration, output
//   register.
// Throughput: one beat per cycle unless out_ch stalls. Every stage is an
//   unrolled iteration copy with its own valid bit; items never share a unit.
// Stall: each stage holds its beat while the stage after it is full and
//   not draining; empty stages keep filling, so bubbles close up. in_ch.ready
//   falls only once the whole pipeline is full behind a stalled out_ch.
// Reset: synchronous, active low; clears all valid bits, not the data.
//
module heading_error_angle #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input logic       clk,
  input logic       rst_n,
  hea_in_if.sink    in_ch,
  hea_out_if.source out_ch
);
  import hea_pkg::*;

  localparam int N_STG = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;

  stage_t pipe_data  [0:N_STG];
  logic   pipe_valid [0:N_STG];
  logic   pipe_ready [0:N_STG];

  // Entry stage
  hea_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .heading  (in_ch.heading),
    .tgt_x    (in_ch.tgt_x),
    .tgt_y    (in_ch.tgt_y),
    .dn_valid (pipe_valid[0]),
    .dn_ready (pipe_ready[0]),
    .dn_data  (pipe_data[0])
  );

  // Unrolled CORDIC iterations
  for (genvar g = 0; g < N_STG; g++) begin : g_stage
    hea_cordic_stage #(
      .STAGE_IDX (g)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (pipe_valid[g]),
      .up_ready (pipe_ready[g]),
      .up_data  (pipe_data[g]),
      .dn_valid (pipe_valid[g+1]),
      .dn_ready (pipe_ready[g+1]),
      .dn_data  (pipe_data[g+1])
    );
  end

  // Result stage
  hea_post u_post (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (pipe_valid[N_STG]),
    .up_ready      (pipe_ready[N_STG]),
    .up_data       (pipe_data[N_STG]),
    .dn_valid      (out_ch.valid),
    .dn_ready      (out_ch.ready),
    .control_angle (out_ch.control_angle),
    .degenerate    (out_ch.degenerate)
  );

  // A degenerate beat always carries a zero angle
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.degenerate |-> out_ch.control_angle == '0)
    else $error("degenerate beat with nonzero control_angle");

  // Result stays within the unwrapped difference range
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.control_angle >= -OUT_W'(DEG360_OUT - 1)) &&
                     (out_ch.control_angle <= OUT_W'(DEG360_OUT)))
    else $error("control_angle out of range");

  // An empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled while output register empty");

  // The entry stage fills on an accepted beat
  a_entry_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> pipe_valid[0])
    else $error("accepted beat lost at entry stage");

endmodule
